// File: rtl/core/jmsc_pkg.sv
// ----------------------------------------------------------------------------
// jmsc_pkg
// types, codes and byte constants for the jpeg marker structure checker
// ----------------------------------------------------------------------------
package jmsc_pkg;

    localparam int COUNT_BITS = 25;
    localparam int MAX_BYTES_BITS = 25;
    localparam int CMP_BITS = (COUNT_BITS > MAX_BYTES_BITS) ? COUNT_BITS : MAX_BYTES_BITS;
    localparam int DIM_BITS = 16;
    localparam int PIX_BITS = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 2;

    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_MAX_ENCODED_BYTES = 2'd0;
    localparam cfg_addr_t CFG_MAX_DIMENSION = 2'd1;
    localparam cfg_addr_t CFG_MAX_PIXELS = 2'd2;

    localparam logic [MAX_BYTES_BITS-1:0] RST_MAX_ENCODED_BYTES = 25'd16777216;
    localparam logic [DIM_BITS-1:0] RST_MAX_DIMENSION = 16'd8192;
    localparam logic [PIX_BITS-1:0] RST_MAX_PIXELS = 32'd67108864;

    typedef logic [3:0] status_t;
    localparam status_t ST_OK = 4'd0;
    localparam status_t ST_TOO_LARGE = 4'd1;
    localparam status_t ST_ENVELOPE = 4'd2;
    localparam status_t ST_STRAY_DATA = 4'd3;
    localparam status_t ST_ENDS_IN_MARKER = 4'd4;
    localparam status_t ST_STUFFED = 4'd5;
    localparam status_t ST_META = 4'd6;
    localparam status_t ST_NESTED_SOI = 4'd7;
    localparam status_t ST_RESTART = 4'd8;
    localparam status_t ST_LEN_TRUNC = 4'd9;
    localparam status_t ST_LEN_INVALID = 4'd10;
    localparam status_t ST_FRAME_SHORT = 4'd11;
    localparam status_t ST_ZERO_DIM = 4'd12;
    localparam status_t ST_DIM_LIMIT = 4'd13;
    localparam status_t ST_NO_EOI = 4'd14;

    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_FILL   = 5'b00010,
        PH_LEN_HI = 5'b00100,
        PH_LEN_LO = 5'b01000,
        PH_BODY   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_SOF   = 2'd1,
        KIND_SOS   = 2'd2
    } kind_t;

    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;
    localparam logic [7:0] BYTE_SOS = 8'hDA;
    localparam logic [7:0] BYTE_SOF_LO = 8'hC0;
    localparam logic [7:0] BYTE_SOF_HI = 8'hCF;
    localparam logic [7:0] BYTE_DHT = 8'hC4;
    localparam logic [7:0] BYTE_JPG = 8'hC8;
    localparam logic [7:0] BYTE_DAC = 8'hCC;
    localparam logic [7:0] BYTE_RST_LO = 8'hD0;
    localparam logic [7:0] BYTE_RST_HI = 8'hD7;
    localparam logic [7:0] BYTE_TEM = 8'h01;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [2:0] POS_HEIGHT_HI = 3'd1;
    localparam logic [2:0] POS_HEIGHT_LO = 3'd2;
    localparam logic [2:0] POS_WIDTH_HI = 3'd3;
    localparam logic [2:0] POS_WIDTH_LO = 3'd4;
    localparam logic [2:0] POS_LAST = 3'd5;
    localparam logic [15:0] SOF_MIN_LEN = 16'd8;
    localparam logic [15:0] SEG_MIN_LEN = 16'd2;

    function automatic logic is_sof(input logic [7:0] m);
        is_sof = (m >= BYTE_SOF_LO) && (m <= BYTE_SOF_HI) && (m != BYTE_DHT)
            && (m != BYTE_JPG) && (m != BYTE_DAC);
    endfunction

endpackage

// File: rtl/core/jpeg_marker_structure_checker.sv
// ----------------------------------------------------------------------------
// result: the status of an image is registered onto m_axis when its final byte
// is accepted, or held in the skid register while m_axis is stalled
// throughput: one byte per cycle unless the skid register is full; the
// pixel-limit product is built over the two width bytes and compared on the following byte
// reset: image state clears except the pixel-product registers, limits return to their defaults
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// jpeg_marker_structure_checker
// walks the marker structure of one encoded image and reports one status
// ----------------------------------------------------------------------------
module jpeg_marker_structure_checker
    import jmsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // data_byte
    input  logic                     s_axis_tlast,  // final_byte
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [7:0]               m_axis_tdata   // status[3:0], image_ok[4], zero pad
);

    logic [MAX_BYTES_BITS-1:0] max_bytes_reg;
    logic [DIM_BITS-1:0]       max_dim_reg;
    logic [PIX_BITS-1:0]       max_pix_reg;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    phase_t                phase_reg, phase_next;
    kind_t                 kind_reg, kind_next;
    logic                  in_scan_reg, in_scan_next;
    logic                  found_frame_reg, found_frame_next;
    logic                  found_scan_reg, found_scan_next;
    logic                  end_seen_reg, end_seen_next;
    logic                  header_good_reg, header_good_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [7:0]            prev_reg, prev_next;
    logic [15:0]           seg_left_reg, seg_left_next;
    logic [7:0]            len_hi_reg, len_hi_next;
    logic [2:0]            seg_pos_reg, seg_pos_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [7:0]            width_hi_reg, width_hi_next;
    logic [23:0]           prod_hi_reg, prod_hi_next;
    logic [PIX_BITS-1:0]   product_reg, product_next;
    logic                  pix_check_reg, pix_check_next;
    status_t               pending_reg, pending_next;
    status_t               first_err_reg, first_err_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic                  out_ok_reg, out_ok_next;
    logic                  skid_valid_reg, skid_valid_next;
    status_t               skid_status_reg, skid_status_next;
    logic                  skid_ok_reg, skid_ok_next;

    logic                  in_fire;
    logic                  out_take;
    logic                  produce;
    logic [7:0]            b;
    logic                  last;
    status_t               pending_eff;
    status_t               status;
    logic [15:0]           seg_len;
    logic [15:0]           left_dec;
    logic [DIM_BITS-1:0]   width_full;
    logic [CMP_BITS-1:0]   count_cmp;
    logic [CMP_BITS-1:0]   max_bytes_cmp;
    logic                  end_seg;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;
    assign b = s_axis_tdata;
    assign last = s_axis_tlast;
    assign produce = in_fire && last;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {3'b000, out_ok_reg, out_status_reg};

    assign pending_eff = (pix_check_reg && (product_reg > max_pix_reg)) ? ST_DIM_LIMIT
                                                                        : pending_reg;
    assign seg_len = {len_hi_reg, b};
    assign left_dec = seg_left_reg - 16'd1;
    assign width_full = {width_hi_reg, b};
    assign count_cmp = CMP_BITS'(count_reg);
    assign max_bytes_cmp = CMP_BITS'(max_bytes_reg);

    // configuration limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= RST_MAX_ENCODED_BYTES;
            max_dim_reg <= RST_MAX_DIMENSION;
            max_pix_reg <= RST_MAX_PIXELS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_MAX_ENCODED_BYTES: max_bytes_reg <= cfg_wdata[MAX_BYTES_BITS-1:0];
                CFG_MAX_DIMENSION:     max_dim_reg <= cfg_wdata[DIM_BITS-1:0];
                CFG_MAX_PIXELS:        max_pix_reg <= cfg_wdata[PIX_BITS-1:0];
                default:               ;
            endcase
        end
    end

    // marker walk
    always_comb
    begin
        phase_next = phase_reg;
        kind_next = kind_reg;
        in_scan_next = in_scan_reg;
        found_frame_next = found_frame_reg;
        found_scan_next = found_scan_reg;
        end_seen_next = end_seen_reg;
        header_good_next = header_good_reg;
        count_next = count_reg;
        prev_next = prev_reg;
        seg_left_next = seg_left_reg;
        len_hi_next = len_hi_reg;
        seg_pos_next = seg_pos_reg;
        height_next = height_reg;
        width_hi_next = width_hi_reg;
        prod_hi_next = prod_hi_reg;
        product_next = product_reg;
        pix_check_next = pix_check_reg;
        pending_next = pending_reg;
        first_err_next = first_err_reg;
        end_seg = 1'b0;
        status = ST_OK;

        if (in_fire)
        begin
            pending_next = pending_eff;
            pix_check_next = 1'b0;

            if (count_reg == '0)
            begin
                header_good_next = (b == BYTE_FF);
            end
            else if (count_reg == COUNT_BITS'(1))
            begin
                header_good_next = header_good_reg && (b == BYTE_SOI);
            end
            else if ((first_err_reg == ST_OK) && !end_seen_reg)
            begin
                case (phase_reg)
                    PH_PREFIX:
                    begin
                        if (b == BYTE_FF)
                        begin
                            phase_next = PH_FILL;
                            if (last)
                                first_err_next = ST_ENDS_IN_MARKER;
                        end
                        else if (!in_scan_reg)
                        begin
                            first_err_next = ST_STRAY_DATA;
                        end
                    end
                    PH_FILL:
                    begin
                        if (b == BYTE_FF)
                        begin
                            if (last)
                                first_err_next = ST_ENDS_IN_MARKER;
                        end
                        else
                        begin
                            phase_next = PH_PREFIX;
                            if (b == BYTE_ZERO)
                            begin
                                if (!in_scan_reg)
                                    first_err_next = ST_STUFFED;
                            end
                            else if (b == BYTE_EOI)
                            begin
                                if (last && found_frame_reg && found_scan_reg)
                                    end_seen_next = 1'b1;
                                else
                                    first_err_next = ST_META;
                            end
                            else if (b == BYTE_SOI)
                            begin
                                first_err_next = ST_NESTED_SOI;
                            end
                            else if (b == BYTE_TEM)
                            begin
                                first_err_next = first_err_reg;
                            end
                            else if ((b >= BYTE_RST_LO) && (b <= BYTE_RST_HI))
                            begin
                                if (!in_scan_reg)
                                    first_err_next = ST_RESTART;
                            end
                            else
                            begin
                                in_scan_next = 1'b0;
                                if (is_sof(b))
                                    kind_next = KIND_SOF;
                                else if (b == BYTE_SOS)
                                    kind_next = KIND_SOS;
                                else
                                    kind_next = KIND_OTHER;
                                pending_next = ST_OK;
                                seg_pos_next = 3'd0;
                                phase_next = PH_LEN_HI;
                                if (last)
                                    first_err_next = ST_LEN_TRUNC;
                            end
                        end
                    end
                    PH_LEN_HI:
                    begin
                        len_hi_next = b;
                        phase_next = PH_LEN_LO;
                        if (last)
                            first_err_next = ST_LEN_TRUNC;
                    end
                    PH_LEN_LO:
                    begin
                        if (seg_len < SEG_MIN_LEN)
                        begin
                            first_err_next = ST_LEN_INVALID;
                        end
                        else
                        begin
                            seg_left_next = seg_len - SEG_MIN_LEN;
                            if ((kind_reg == KIND_SOF) && (seg_len < SOF_MIN_LEN))
                                pending_next = ST_FRAME_SHORT;
                            if (seg_len == SEG_MIN_LEN)
                            begin
                                end_seg = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                                if (last)
                                    first_err_next = ST_LEN_INVALID;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        if ((kind_reg == KIND_SOF) && (pending_eff == ST_OK))
                        begin
                            if (seg_pos_reg == POS_HEIGHT_HI)
                            begin
                                height_next = {b, 8'h00};
                            end
                            else if (seg_pos_reg == POS_HEIGHT_LO)
                            begin
                                height_next = {height_reg[15:8], b};
                            end
                            else if (seg_pos_reg == POS_WIDTH_HI)
                            begin
                                width_hi_next = b;
                                prod_hi_next = {8'h00, height_reg} * {16'h0000, b};
                            end
                            else if (seg_pos_reg == POS_WIDTH_LO)
                            begin
                                product_next = {prod_hi_reg, 8'h00}
                                    + PIX_BITS'({8'h00, height_reg} * {16'h0000, b});
                                if ((width_full == '0) || (height_reg == '0))
                                    pending_next = ST_ZERO_DIM;
                                else if ((width_full > max_dim_reg)
                                    || (height_reg > max_dim_reg))
                                    pending_next = ST_DIM_LIMIT;
                                else
                                    pix_check_next = 1'b1;
                            end
                        end
                        if (seg_pos_reg < POS_LAST)
                            seg_pos_next = seg_pos_reg + 3'd1;
                        seg_left_next = left_dec;
                        if (left_dec == 16'd0)
                            end_seg = 1'b1;
                        else if (last)
                            first_err_next = ST_LEN_INVALID;
                    end
                    default:
                    begin
                        phase_next = PH_PREFIX;
                    end
                endcase

                if (end_seg)
                begin
                    phase_next = PH_PREFIX;
                    if (pending_next != ST_OK)
                    begin
                        first_err_next = pending_next;
                    end
                    else
                    begin
                        if (kind_reg == KIND_SOF)
                            found_frame_next = 1'b1;
                        if (kind_reg == KIND_SOS)
                        begin
                            found_scan_next = 1'b1;
                            in_scan_next = 1'b1;
                        end
                    end
                end
            end

            if (!last)
            begin
                prev_next = b;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + COUNT_BITS'(1);
            end
            else
            begin
                // size over limit, then envelope, then walk result
                if (count_cmp >= max_bytes_cmp)
                    status = ST_TOO_LARGE;
                else if ((count_reg < COUNT_BITS'(3)) || !header_good_next
                    || (prev_reg != BYTE_FF) || (b != BYTE_EOI))
                    status = ST_ENVELOPE;
                else if (first_err_next != ST_OK)
                    status = first_err_next;
                else if (end_seen_next)
                    status = ST_OK;
                else
                    status = ST_NO_EOI;

                phase_next = PH_PREFIX;
                kind_next = KIND_OTHER;
                in_scan_next = 1'b0;
                found_frame_next = 1'b0;
                found_scan_next = 1'b0;
                end_seen_next = 1'b0;
                header_good_next = 1'b0;
                count_next = '0;
                prev_next = 8'h00;
                seg_left_next = 16'd0;
                len_hi_next = 8'h00;
                seg_pos_next = 3'd0;
                height_next = '0;
                width_hi_next = 8'h00;
                pix_check_next = 1'b0;
                pending_next = ST_OK;
                first_err_next = ST_OK;
            end
        end
    end

    // result register with skid stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_ok_next = out_ok_reg;
        skid_valid_next = skid_valid_reg;
        skid_status_next = skid_status_reg;
        skid_ok_next = skid_ok_reg;

        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_status_next = skid_status_reg;
                out_ok_next = skid_ok_reg;
                skid_valid_next = 1'b0;
            end
            else if (produce)
            begin
                out_valid_next = 1'b1;
                out_status_next = status;
                out_ok_next = (status == ST_OK);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_status_next = status;
            skid_ok_next = (status == ST_OK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            kind_reg <= KIND_OTHER;
            in_scan_reg <= 1'b0;
            found_frame_reg <= 1'b0;
            found_scan_reg <= 1'b0;
            end_seen_reg <= 1'b0;
            header_good_reg <= 1'b0;
            count_reg <= '0;
            prev_reg <= 8'h00;
            seg_left_reg <= 16'd0;
            len_hi_reg <= 8'h00;
            seg_pos_reg <= 3'd0;
            height_reg <= '0;
            width_hi_reg <= 8'h00;
            pix_check_reg <= 1'b0;
            pending_reg <= ST_OK;
            first_err_reg <= ST_OK;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg <= kind_next;
            in_scan_reg <= in_scan_next;
            found_frame_reg <= found_frame_next;
            found_scan_reg <= found_scan_next;
            end_seen_reg <= end_seen_next;
            header_good_reg <= header_good_next;
            count_reg <= count_next;
            prev_reg <= prev_next;
            seg_left_reg <= seg_left_next;
            len_hi_reg <= len_hi_next;
            seg_pos_reg <= seg_pos_next;
            height_reg <= height_next;
            width_hi_reg <= width_hi_next;
            pix_check_reg <= pix_check_next;
            pending_reg <= pending_next;
            first_err_reg <= first_err_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        product_reg <= product_next;
        out_status_reg <= out_status_next;
        out_ok_reg <= out_ok_next;
        skid_status_reg <= skid_status_next;
        skid_ok_reg <= skid_ok_next;
    end

endmodule
